// ----- src/cc20_pkg.sv -----
// Shared types, constants and helpers for the ChaCha20 block function.
// No dependencies; compiled first.
package cc20_pkg;

  localparam int unsigned WORD_W            = 32;
  localparam int unsigned N_WORDS           = 16;
  localparam int unsigned FIELD_W           = 64;
  localparam int unsigned N_FIELDS          = 8;
  localparam int unsigned ROUND_COUNT_DEF   = 20;

  // rotation amounts of the quarter round
  localparam int unsigned ROT_A = 16;
  localparam int unsigned ROT_B = 12;
  localparam int unsigned ROT_C = 8;
  localparam int unsigned ROT_D = 7;

  typedef logic [WORD_W-1:0]             word_t;
  typedef word_t [N_WORDS-1:0]           state_t;
  typedef logic [FIELD_W-1:0]            field_t;

  // one pipeline slot: the mixed words and the original input words
  typedef struct packed {
    state_t work;
    state_t init;
  } pipe_t;

  // rotate left by a constant amount (1 .. WORD_W-1)
  function automatic word_t rotl(input word_t v, input int unsigned s);
    word_t r;
    r = (v << s) | (v >> (WORD_W - s));
    return r;
  endfunction

endpackage

// ----- src/cc20_if.sv -----
// Handshake interfaces for the input state and the keystream block channels.
// Depends on cc20_pkg.
interface cc20_in_if;
  import cc20_pkg::*;

  logic   valid;
  logic   ready;
  field_t state_w0_w1;
  field_t state_w2_w3;
  field_t state_w4_w5;
  field_t state_w6_w7;
  field_t state_w8_w9;
  field_t state_w10_w11;
  field_t state_w12_w13;
  field_t state_w14_w15;

  modport source (
    output valid, state_w0_w1, state_w2_w3, state_w4_w5, state_w6_w7,
           state_w8_w9, state_w10_w11, state_w12_w13, state_w14_w15,
    input  ready
  );
  modport sink (
    input  valid, state_w0_w1, state_w2_w3, state_w4_w5, state_w6_w7,
           state_w8_w9, state_w10_w11, state_w12_w13, state_w14_w15,
    output ready
  );
endinterface

interface cc20_out_if;
  import cc20_pkg::*;

  logic   valid;
  logic   ready;
  field_t block_w0_w1;
  field_t block_w2_w3;
  field_t block_w4_w5;
  field_t block_w6_w7;
  field_t block_w8_w9;
  field_t block_w10_w11;
  field_t block_w12_w13;
  field_t block_w14_w15;

  modport source (
    output valid, block_w0_w1, block_w2_w3, block_w4_w5, block_w6_w7,
           block_w8_w9, block_w10_w11, block_w12_w13, block_w14_w15,
    input  ready
  );
  modport sink (
    input  valid, block_w0_w1, block_w2_w3, block_w4_w5, block_w6_w7,
           block_w8_w9, block_w10_w11, block_w12_w13, block_w14_w15,
    output ready
  );
endinterface

// ----- src/cc20_cell.sv -----
// One half-round cell: the first or second half of four parallel quarter
// rounds, column or diagonal. Depends on cc20_pkg.
module cc20_cell #(
  parameter bit DIAG   = 1'b0,  // diagonal round when set, column round otherwise
  parameter bit SECOND = 1'b0   // second half (rotations 8, 7) when set
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  cc20_pkg::pipe_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output cc20_pkg::pipe_t out_data
);
  import cc20_pkg::*;

  localparam int unsigned RS0 = SECOND ? ROT_C : ROT_A;
  localparam int unsigned RS1 = SECOND ? ROT_D : ROT_B;
  localparam int unsigned SH  = DIAG ? 1 : 0;

  pipe_t data_next;

  // four independent quarter-round halves
  always_comb begin
    data_next = in_data;
    for (int q = 0; q < 4; q++) begin
      word_t a, b, c, d;
      a = in_data.work[q];
      b = in_data.work[4  + ((q + SH)     % 4)];
      c = in_data.work[8  + ((q + 2 * SH) % 4)];
      d = in_data.work[12 + ((q + 3 * SH) % 4)];
      a = a + b;
      d = rotl(d ^ a, RS0);
      c = c + d;
      b = rotl(b ^ c, RS1);
      data_next.work[q]                      = a;
      data_next.work[4  + ((q + SH)     % 4)] = b;
      data_next.work[8  + ((q + 2 * SH) % 4)] = c;
      data_next.work[12 + ((q + 3 * SH) % 4)] = d;
    end
  end

  // slot is free when empty or when the neighbour takes it
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ----- src/cc20_final.sv -----
// Feed-forward cell: adds the input state to the mixed state word by word
// and holds the keystream block. Depends on cc20_pkg.
module cc20_final (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  cc20_pkg::pipe_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output cc20_pkg::state_t out_data
);
  import cc20_pkg::*;

  state_t sum_next;

  // sixteen independent 32-bit adds, wrapping
  always_comb begin
    for (int k = 0; k < N_WORDS; k++) begin
      sum_next[k] = in_data.work[k] + in_data.init[k];
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= sum_next;
    end
  end

endmodule

// ----- src/chacha20_block_function.sv -----
// ChaCha20 block function top level: a chain of half-round cells and a
// feed-forward cell. Depends on cc20_pkg, cc20_if, cc20_cell, cc20_final.
//
//  channel  | direction | payload                          | per transaction
//  ---------+-----------+----------------------------------+----------------------
//  in_ch    | sink      | state_w0_w1 .. state_w14_w15     | one 512-bit state
//  out_ch   | source    | block_w0_w1 .. block_w14_w15     | one keystream block
//
// Throughput is one transaction per cycle while the receiver takes every block;
// each transaction passes through the chain of cells (two per round, two 32-bit
// adds each) and then the feed-forward add.
// Every cell has its own valid flag and takes a new transaction whenever it is
// empty or its neighbour takes its content, so stalls fill bubbles first.
// Synchronous reset clears the valid flags only; data registers are not reset.
module chacha20_block_function #(
  parameter int unsigned ROUND_COUNT = cc20_pkg::ROUND_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  cc20_in_if.sink    in_ch,
  cc20_out_if.source out_ch
);
  import cc20_pkg::*;

  localparam int unsigned N_CELLS = 2 * ROUND_COUNT;

  pipe_t  stage_data  [N_CELLS+1];
  logic   stage_valid [N_CELLS+1];
  logic   stage_ready [N_CELLS+1];
  state_t in_state;
  state_t block;

  // unpack the input transaction; the copy to be mixed starts equal to it
  assign in_state = {in_ch.state_w14_w15, in_ch.state_w12_w13,
                     in_ch.state_w10_w11, in_ch.state_w8_w9,
                     in_ch.state_w6_w7,   in_ch.state_w4_w5,
                     in_ch.state_w2_w3,   in_ch.state_w0_w1};
  assign stage_data[0] = {in_state, in_state};

  assign stage_valid[0] = in_ch.valid;
  assign in_ch.ready    = stage_ready[0];

  // chain of half-round cells: even rounds are column rounds, odd diagonal
  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    cc20_cell #(
      .DIAG   (bit'((i / 2) % 2)),
      .SECOND (bit'(i % 2))
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[i]),
      .in_ready  (stage_ready[i]),
      .in_data   (stage_data[i]),
      .out_valid (stage_valid[i+1]),
      .out_ready (stage_ready[i+1]),
      .out_data  (stage_data[i+1])
    );
  end

  // feed-forward add and output register
  cc20_final u_final (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stage_valid[N_CELLS]),
    .in_ready  (stage_ready[N_CELLS]),
    .in_data   (stage_data[N_CELLS]),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (block)
  );

  // repack the keystream block
  assign out_ch.block_w0_w1   = {block[1],  block[0]};
  assign out_ch.block_w2_w3   = {block[3],  block[2]};
  assign out_ch.block_w4_w5   = {block[5],  block[4]};
  assign out_ch.block_w6_w7   = {block[7],  block[6]};
  assign out_ch.block_w8_w9   = {block[9],  block[8]};
  assign out_ch.block_w10_w11 = {block[11], block[10]};
  assign out_ch.block_w12_w13 = {block[13], block[12]};
  assign out_ch.block_w14_w15 = {block[15], block[14]};

endmodule

// ----- tb/tb_chacha20_block_function.sv -----
`timescale 1ns / 100ps
// Testbench for the ChaCha20 block function: a keystream scoreboard class plus
// handshake driver tasks. Depends on cc20_pkg, cc20_if and chacha20_block_function.
module tb_chacha20_block_function;
  import cc20_pkg::*;

  localparam int unsigned ROUNDS      = ROUND_COUNT_DEF;
  localparam int unsigned N_ITEMS     = 1250;
  localparam int unsigned LIMIT_CYCLES = 200_000;
  localparam int unsigned MAX_REPORTS = 40;

  // "expand 32-byte k"
  localparam word_t SIGMA0 = 32'h6170_7865;
  localparam word_t SIGMA1 = 32'h3320_646e;
  localparam word_t SIGMA2 = 32'h7962_2d32;
  localparam word_t SIGMA3 = 32'h6b20_6574;

  // field k at index k; the same 512 bits viewed as state_t give word i at index i
  typedef logic [N_FIELDS-1:0][FIELD_W-1:0] state512_t;

  // Keystream scoreboard: predicts each block and checks results in order
  class keystream_board;
    state512_t   expected_blocks[$];
    int unsigned mismatches;
    int unsigned states_taken;
    int unsigned blocks_checked;

    function word_t rotate_left(word_t v, int unsigned s);
      logic [63:0] twice;
      twice = {v, v} << s;
      return twice[63:32];
    endfunction

    function void quarter_mix(inout state_t w, input int a, input int b,
                              input int c, input int d);
      w[a] = w[a] + w[b]; w[d] = rotate_left(w[d] ^ w[a], ROT_A);
      w[c] = w[c] + w[d]; w[b] = rotate_left(w[b] ^ w[c], ROT_B);
      w[a] = w[a] + w[b]; w[d] = rotate_left(w[d] ^ w[a], ROT_C);
      w[c] = w[c] + w[d]; w[b] = rotate_left(w[b] ^ w[c], ROT_D);
    endfunction

    function state512_t keystream_of(state512_t st);
      state_t init;
      state_t work;
      init = st;
      work = init;
      for (int r = 0; r < ROUNDS; r++) begin
        if (r % 2 == 0) begin
          // column round
          quarter_mix(work, 0, 4, 8, 12);
          quarter_mix(work, 1, 5, 9, 13);
          quarter_mix(work, 2, 6, 10, 14);
          quarter_mix(work, 3, 7, 11, 15);
        end else begin
          // diagonal round
          quarter_mix(work, 0, 5, 10, 15);
          quarter_mix(work, 1, 6, 11, 12);
          quarter_mix(work, 2, 7, 8, 13);
          quarter_mix(work, 3, 4, 9, 14);
        end
      end
      // feed-forward of the input words
      for (int k = 0; k < N_WORDS; k++) work[k] = work[k] + init[k];
      return work;
    endfunction

    function void note_state(state512_t st);
      expected_blocks.push_back(keystream_of(st));
      states_taken++;
    endfunction

    function void check_block(state512_t got);
      state512_t want;
      if (expected_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: keystream block with no state pending: %h", $time, got);
        return;
      end
      want = expected_blocks.pop_front();
      blocks_checked++;
      for (int k = 0; k < N_FIELDS; k++) begin
        if (got[k] !== want[k]) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: block_w%0d_w%0d expected %h actual %h",
                     $time, 2 * k, 2 * k + 1, want[k], got[k]);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_blocks.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   no_idle = 1'b0;
  int unsigned cycles = 0;

  keystream_board board = new();

  // running stream: one key and nonce, counter stepping per block
  word_t       stream_key [8];
  word_t       stream_nonce [3];
  word_t       stream_ctr;
  int unsigned stream_left = 0;

  cc20_in_if  in_ch();
  cc20_out_if out_ch();

  chacha20_block_function #(.ROUND_COUNT(ROUNDS)) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  // known values on every input from time zero
  initial begin
    in_ch.valid = 1'b0;
    {in_ch.state_w14_w15, in_ch.state_w12_w13, in_ch.state_w10_w11, in_ch.state_w8_w9,
     in_ch.state_w6_w7, in_ch.state_w4_w5, in_ch.state_w2_w3, in_ch.state_w0_w1} = '0;
    out_ch.ready = 1'b0;
  end

  // receiver back-pressure, changed on the falling edge
  always @(negedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= no_idle || ($urandom_range(99) >= 33);
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      board.check_block({out_ch.block_w14_w15, out_ch.block_w12_w13,
                         out_ch.block_w10_w11, out_ch.block_w8_w9,
                         out_ch.block_w6_w7, out_ch.block_w4_w5,
                         out_ch.block_w2_w3, out_ch.block_w0_w1});
  end

  // watchdog
  initial begin
    while (cycles < LIMIT_CYCLES) @(posedge clk) cycles++;
    $display("tb_chacha20_block_function NOT OK");
    $finish;
  end

  // Offer one state; entered and left on a falling edge
  task automatic send_state(input state512_t st);
    while (!no_idle && $urandom_range(99) < 33) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.state_w14_w15, in_ch.state_w12_w13, in_ch.state_w10_w11, in_ch.state_w8_w9,
     in_ch.state_w6_w7, in_ch.state_w4_w5, in_ch.state_w2_w3, in_ch.state_w0_w1} <= st;
    do @(posedge clk); while (!in_ch.ready);
    board.note_state(st);
    @(negedge clk);
  endtask

  // Hold off the sender until every pending block has come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Standard layout: constants, key, counter, nonce
  function automatic state512_t layout_state(input word_t ctr, input int unsigned key_base,
                                             input word_t n0, input word_t n1,
                                             input word_t n2);
    state_t w;
    w[0] = SIGMA0; w[1] = SIGMA1; w[2] = SIGMA2; w[3] = SIGMA3;
    for (int k = 0; k < 8; k++) w[4 + k] = key_base + 32'h0404_0404 * k;
    w[12] = ctr; w[13] = n0; w[14] = n1; w[15] = n2;
    return w;
  endfunction

  function automatic state512_t random_state();
    state_t      w;
    state512_t   st;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      // block stream with a fresh key now and then
      if (stream_left == 0) begin
        for (int k = 0; k < 8; k++) stream_key[k] = $urandom;
        for (int k = 0; k < 3; k++) stream_nonce[k] = $urandom;
        stream_ctr = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(3) : $urandom;
        stream_left = $urandom_range(1, 12);
      end
      w[0] = SIGMA0; w[1] = SIGMA1; w[2] = SIGMA2; w[3] = SIGMA3;
      for (int k = 0; k < 8; k++) w[4 + k] = stream_key[k];
      w[12] = stream_ctr;
      for (int k = 0; k < 3; k++) w[13 + k] = stream_nonce[k];
      stream_ctr++;
      stream_left--;
      st = w;
    end else if (pick < 85) begin
      for (int k = 0; k < N_WORDS; k++) w[k] = $urandom;
      st = w;
    end else if (pick < 95) begin
      // fields at the extremes mixed with random ones
      for (int k = 0; k < N_FIELDS; k++) begin
        case ($urandom_range(2))
          0: st[k] = '0;
          1: st[k] = '1;
          default: st[k] = {$urandom, $urandom};
        endcase
      end
    end else begin
      // all zeros or all ones with one bit flipped somewhere in the 512
      st = $urandom_range(1) ? '1 : '0;
      st[$urandom_range(N_FIELDS - 1)][$urandom_range(FIELD_W - 1)] ^= 1'b1;
    end
    return st;
  endfunction

  // Stimulus
  initial begin
    state512_t st;
    state_t    w;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, single full fields, bit patterns, standard layout
    send_state('0);
    send_state('1);
    for (int k = 0; k < N_FIELDS; k++) begin
      st = '0;
      st[k] = '1;
      send_state(st);
    end
    send_state({64{8'h55}});
    send_state({64{8'hAA}});
    send_state(layout_state(32'h0000_0001, 32'h0302_0100, 32'h0900_0000, 32'h4a00_0000, '0));
    send_state(layout_state(32'hFFFF_FFFF, 32'h0302_0100, 32'h0900_0000, 32'h4a00_0000, '0));
    send_state(layout_state(32'h0000_0000, 32'h0302_0100, 32'h0900_0000, 32'h4a00_0000, '0));
    for (int k = 0; k < N_WORDS; k++) w[k] = 32'h8000_0000;
    send_state(w);
    for (int k = 0; k < N_WORDS; k++) w[k] = 32'h0000_0001;
    send_state(w);
    for (int k = 0; k < N_WORDS; k++) w[k] = k;
    send_state(w);

    // random states, with a stretch of full throughput and one full drain
    for (int i = 0; i < N_ITEMS; i++) begin
      no_idle = (i >= 500 && i < 700);
      if (i == 900) drain();
      send_state(random_state());
    end
    no_idle = 1'b0;
    in_ch.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (2 * ROUNDS + 20) @(posedge clk);

    $display("Sent %0d states (directed extremes, standard layouts, counter runs, random)",
             board.states_taken);
    $display("and checked %0d keystream blocks of %0d rounds under random idle and stall",
             board.blocks_checked, ROUNDS);
    if (board.mismatches == 0 && board.pending() == 0)
      $display("tb_chacha20_block_function OK");
    else
      $display("tb_chacha20_block_function NOT OK");
    $finish;
  end

endmodule
